// ===== rtl/poincare_singular_point_detector_assert.svh =====
// assertion macros used by the checker file
// no dependencies; every macro samples on the rising clock edge and stays quiet in reset
`ifndef POINCARE_SINGULAR_POINT_DETECTOR_ASSERT_SVH
`define POINCARE_SINGULAR_POINT_DETECTOR_ASSERT_SVH

// same-cycle implication
`define PSD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psd_pkg.sv =====
// shared types, constants and helpers of the singular point detector
// no dependencies; imported by every module of the block except psd_ram
package psd_pkg;

  // default sizes of the grid
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;

  // field widths
  localparam int ORI_W   = 13;
  localparam int DIFF_W  = 15;
  localparam int ACC_W   = 18;
  localparam int SUM_W   = 15;
  localparam int POS_W   = 6;
  localparam int GC_W    = 7;
  localparam int TOL_W   = 11;
  localparam int LINE_W  = 2 * ORI_W;
  localparam int WIN_N   = 9;

  // angles in 1/16 degree
  localparam int QUARTER_TURN = 1440;
  localparam int HALF_TURN    = 2880;
  localparam int FULL_TURN    = 5760;
  localparam int SUM_LIMIT    = 11520;

  // register reset values
  localparam logic [GC_W-1:0]  GRID_COLUMNS_RST = 7'd32;
  localparam logic [TOL_W-1:0] TOLERANCE_RST    = 11'd800;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_TOLERANCE    = 1'b1
  } psd_reg_e;

  // classification of a window center
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOOP  = 2'd1,
    KIND_DELTA = 2'd2,
    KIND_WHORL = 2'd3
  } psd_kind_e;

  // 3x3 window, entry r*3+c, row 0 oldest, column 2 newest
  typedef logic [WIN_N-1:0][ORI_W-1:0] psd_win_t;

  // circle walked around the center
  typedef logic [3:0] ring_idx_t;
  localparam ring_idx_t RING [8] = '{4'd2, 4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8, 4'd5};

  // fold a neighbour difference once into plus or minus 90 degrees
  function automatic logic signed [DIFF_W-1:0] fold(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] r;
    if (d > QUARTER_TURN) begin
      r = DIFF_W'(d - HALF_TURN);
    end else if (d < -QUARTER_TURN) begin
      r = DIFF_W'(d + HALF_TURN);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

// ===== rtl/psd_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
module psd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/psd_front.sv =====
// front end: accepts words, tracks row and column, keeps line buffers and the window
// depends on psd_pkg and psd_ram; pushes complete windows into the queue
module psd_front #(
  parameter int MAX_COLUMNS = psd_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = psd_pkg::DEF_MAX_ROWS,
  parameter int CW          = $clog2(MAX_COLUMNS),
  parameter int RW          = $clog2(MAX_ROWS)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [psd_pkg::GC_W-1:0]            grid_columns_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [psd_pkg::ORI_W-1:0]           orientation_i,
  input  logic                                frame_start_i,
  output logic                                push_o,
  input  logic                                push_ready_i,
  output logic [RW+CW+psd_pkg::WIN_N*psd_pkg::ORI_W-1:0] push_data_o
);
  import psd_pkg::*;

  localparam int LW = (CW + 1 > GC_W) ? CW + 1 : GC_W;

  // position counters
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  // item waiting for its line buffer data
  logic             s1_v_q;
  logic [ORI_W-1:0] s1_x_q;
  logic [CW-1:0]    s1_c_q;
  logic [RW-1:0]    s1_r_q;
  logic             fwd_q;
  logic [LINE_W-1:0] fwd_data_q;

  psd_win_t win_q, win_n;

  logic [LW-1:0]  cols, gc_ext;
  logic [CW-1:0]  cur_c, base_c;
  logic [RW-1:0]  cur_r, base_r;
  logic           acc, s1_adv, need_push;
  logic [LINE_W-1:0] ram_rdata, line_rd, ram_wdata;

  // effective grid width
  assign gc_ext = LW'(grid_columns_i);
  always_comb begin
    if (gc_ext < LW'(3)) begin
      cols = LW'(3);
    end else if (gc_ext > LW'(MAX_COLUMNS)) begin
      cols = LW'(MAX_COLUMNS);
    end else begin
      cols = gc_ext;
    end
  end

  // position of the incoming word
  always_comb begin
    base_c = frame_start_i ? '0 : col_q;
    base_r = frame_start_i ? '0 : row_q;
    cur_c  = (LW'(base_c) >= cols) ? '0 : base_c;
    cur_r  = ((RW+1)'(base_r) >= (RW+1)'(MAX_ROWS)) ? '0 : base_r;
    if (LW'(cur_c) + LW'(1) >= cols) begin
      col_d = '0;
      row_d = ((RW+1)'(cur_r) + (RW+1)'(1) >= (RW+1)'(MAX_ROWS)) ? '0 : RW'(cur_r + RW'(1));
    end else begin
      col_d = CW'(cur_c + CW'(1));
      row_d = cur_r;
    end
  end

  // handshake of the front
  assign need_push  = (s1_r_q >= RW'(2)) && (s1_c_q >= CW'(2));
  assign s1_adv     = s1_v_q && (!need_push || push_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;

  // line buffers: upper half two rows above, lower half one row above
  assign line_rd   = fwd_q ? fwd_data_q : ram_rdata;
  assign ram_wdata = {line_rd[ORI_W-1:0], s1_x_q};

  psd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_c_q),
    .wdata_i (ram_wdata),
    .re_i    (acc),
    .raddr_i (cur_c),
    .rdata_o (ram_rdata)
  );

  // shifted window
  always_comb begin
    win_n    = win_q;
    win_n[0] = win_q[1];
    win_n[1] = win_q[2];
    win_n[2] = line_rd[LINE_W-1:ORI_W];
    win_n[3] = win_q[4];
    win_n[4] = win_q[5];
    win_n[5] = line_rd[ORI_W-1:0];
    win_n[6] = win_q[7];
    win_n[7] = win_q[8];
    win_n[8] = s1_x_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
      win_q  <= '0;
    end else begin
      if (acc) begin
        col_q  <= col_d;
        row_q  <= row_d;
        s1_v_q <= 1'b1;
        fwd_q  <= s1_adv && (s1_c_q == cur_c);
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        win_q <= win_n;
      end
    end
  end

  // payload of the waiting word, plus write data forwarded to a same-column read
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_x_q     <= orientation_i;
      s1_c_q     <= cur_c;
      s1_r_q     <= cur_r;
      fwd_data_q <= ram_wdata;
    end
  end

  assign push_o      = s1_adv && need_push;
  assign push_data_o = {s1_r_q, s1_c_q, win_n};

endmodule

// ===== rtl/psd_queue.sv =====
// two-entry queue between the front and the back end
// depends on psd_pkg only for the import convention
module psd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import psd_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/psd_back.sv =====
// back end: folds and sums the ring differences, saturates and classifies
// depends on psd_pkg; three stages with the result register at the end
module psd_back #(
  parameter int CW = 6,
  parameter int RW = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [psd_pkg::TOL_W-1:0]           tolerance_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [RW+CW+psd_pkg::WIN_N*psd_pkg::ORI_W-1:0] in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [psd_pkg::POS_W-1:0]           center_row_o,
  output logic [psd_pkg::POS_W-1:0]           center_col_o,
  output logic [1:0]                          point_kind_o,
  output logic [psd_pkg::SUM_W-1:0]           index_sum_o
);
  import psd_pkg::*;

  localparam int WB = WIN_N * ORI_W;

  // test a sum against target plus or minus tolerance
  function automatic logic near(input logic signed [17:0] s, input logic signed [17:0] t,
                                input logic signed [17:0] tol);
    logic ok;
    ok = (s >= t - tol) && (s <= t + tol);
    return ok;
  endfunction

  psd_win_t win;
  logic [CW-1:0] in_c;
  logic [RW-1:0] in_r;
  assign win  = in_data_i[WB-1:0];
  assign in_c = in_data_i[WB+CW-1:WB];
  assign in_r = in_data_i[WB+CW+RW-1:WB+CW];

  // stage enables, back to front
  logic v1_q, v2_q, ov_q;
  logic en1, en2, eno;
  assign eno        = !ov_q || out_ready_i;
  assign en2        = !v2_q || eno;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: folded ring differences
  logic signed [DIFF_W-1:0] fd_d [8];
  logic signed [DIFF_W-1:0] fd_q [8];
  logic [CW-1:0] c1_q, c2_q;
  logic [RW-1:0] r1_q, r2_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      fd_d[k] = fold(DIFF_W'($signed(win[RING[k]])) - DIFF_W'($signed(win[RING[(k+1)%8]])));
    end
  end

  // stage 2: sum of the eight
  logic signed [ACC_W-1:0] sum_d, sum_q;
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < 8; k++) begin
      sum_d = sum_d + ACC_W'(fd_q[k]);
    end
  end

  // stage 3: saturation and classification
  logic signed [SUM_W-1:0] sat;
  logic signed [17:0]      sat18, tol18;
  psd_kind_e               kind;
  logic [RW-1:0]           rm1;
  logic [CW-1:0]           cm1;
  logic [RW+POS_W-1:0]     rx;
  logic [CW+POS_W-1:0]     cx;

  always_comb begin
    if (sum_q > SUM_LIMIT) begin
      sat = SUM_W'(SUM_LIMIT);
    end else if (sum_q < -SUM_LIMIT) begin
      sat = SUM_W'(-SUM_LIMIT);
    end else begin
      sat = SUM_W'(sum_q);
    end
    sat18 = 18'(sat);
    tol18 = $signed({7'b0, tolerance_i});
    if (near(sat18, 18'(HALF_TURN), tol18)) begin
      kind = KIND_LOOP;
    end else if (near(sat18, 18'(-HALF_TURN), tol18)) begin
      kind = KIND_DELTA;
    end else if (near(sat18, 18'(FULL_TURN), tol18)) begin
      kind = KIND_WHORL;
    end else begin
      kind = KIND_NONE;
    end
    rm1 = RW'(r2_q - RW'(1));
    cm1 = CW'(c2_q - CW'(1));
    rx  = {{POS_W{1'b0}}, rm1};
    cx  = {{POS_W{1'b0}}, cm1};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (eno) begin
        ov_q <= v2_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en1) begin
      fd_q <= fd_d;
      c1_q <= in_c;
      r1_q <= in_r;
    end
    if (en2) begin
      sum_q <= sum_d;
      c2_q  <= c1_q;
      r2_q  <= r1_q;
    end
    if (eno) begin
      center_row_o <= rx[POS_W-1:0];
      center_col_o <= cx[POS_W-1:0];
      point_kind_o <= kind;
      index_sum_o  <= sat;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ===== rtl/poincare_singular_point_detector.sv =====
// top level of the singular point detector: register port, front, queue and back end
// depends on psd_pkg, psd_front, psd_queue, psd_back (and psd_ram below the front)
//
//  channel   | direction | handshake                  | contents
//  s_axis    | in        | tvalid/tready              | orientation, frame_start
//  m_axis    | out       | tvalid/tready              | center row/col, index sum, kind
//  apb       | in        | psel/penable, pready = 1   | grid_columns, tolerance
//
// one word per cycle in unless the queue is full, one result per interior block; a
// result is offered once its word has passed the line buffer read stage, queue, two
// back end stages and the result register. the line buffer read port sets the front
// at one word per cycle; the back end pipeline sustains the same while m_axis is
// ready. reset clears counters, window and valid bits at once, no clearing pass. the
// two-entry queue lets the front keep taking words while a result waits on m_axis.
module poincare_singular_point_detector #(
  parameter int MAX_COLUMNS = psd_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = psd_pkg::DEF_MAX_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // orientation[12:0], zero pad
  input  logic        s_axis_tuser,   // frame_start
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // center_row[5:0], center_col[11:6], index_sum[26:12]
  output logic [1:0]  m_axis_tuser    // point_kind[1:0]
);
  import psd_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int QW = RW + CW + WIN_N * ORI_W;

  // configuration registers
  logic [GC_W-1:0]  grid_columns_q;
  logic [TOL_W-1:0] tolerance_q;
  logic             cfg_we;
  psd_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = psd_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= GRID_COLUMNS_RST;
      tolerance_q    <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_GRID_COLUMNS: grid_columns_q <= pwdata[GC_W-1:0];
        REG_TOLERANCE:    tolerance_q    <= pwdata[TOL_W-1:0];
        default:          ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_sel)
      REG_GRID_COLUMNS: prdata = {{(32-GC_W){1'b0}}, grid_columns_q};
      REG_TOLERANCE:    prdata = {{(32-TOL_W){1'b0}}, tolerance_q};
      default:          prdata = '0;
    endcase
  end

  // front end
  logic          push, push_ready, q_valid, q_ready;
  logic [QW-1:0] push_data, q_data;

  psd_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .CW          (CW),
    .RW          (RW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .grid_columns_i (grid_columns_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .orientation_i  (s_axis_tdata[ORI_W-1:0]),
    .frame_start_i  (s_axis_tuser),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  // decoupling queue
  psd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  // back end
  logic [POS_W-1:0] center_row, center_col;
  logic [1:0]       point_kind;
  logic [SUM_W-1:0] index_sum;

  psd_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tolerance_i  (tolerance_q),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_data_i    (q_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .center_row_o (center_row),
    .center_col_o (center_col),
    .point_kind_o (point_kind),
    .index_sum_o  (index_sum)
  );

  assign m_axis_tdata = {5'b0, index_sum, center_col, center_row};
  assign m_axis_tuser = point_kind;

endmodule

// ===== rtl/psd_checker.sv =====
// port-level checks of the singular point detector, bound to the top level
// depends on psd_pkg and poincare_singular_point_detector_assert.svh
`include "poincare_singular_point_detector_assert.svh"

module psd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import psd_pkg::*;

  logic signed [SUM_W-1:0] sum;
  assign sum = $signed(m_axis_tdata[26:12]);

  // a stalled result stays offered
  `PSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

  // loop and whorl need a positive sum, delta a negative one
  `PSD_ASSERT_IMPL(a_kind_sign, clk_i, rst_ni, m_axis_tvalid, ((m_axis_tuser != KIND_LOOP && m_axis_tuser != KIND_WHORL) || sum > 0) && (m_axis_tuser != KIND_DELTA || sum < 0), "kind disagrees with sign of index sum")

  // the reported sum is saturated
  `PSD_ASSERT_IMPL(a_sum_range, clk_i, rst_ni, m_axis_tvalid, sum <= SUM_LIMIT && sum >= -SUM_LIMIT, "index sum beyond saturation limit")

  // register port never waits and result padding is clear
  `PSD_ASSERT_IMPL(a_pad_ready, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:27] == 5'b0 && pready, "padding set or register port not ready")

endmodule

bind poincare_singular_point_detector psd_checker u_psd_checker (.*);
